### sv/gbb_pkg.sv
// gbb_pkg: shared widths, register indexes and interface types of the
// glyph bitmap blitter. No dependencies.
package gbb_pkg;

  localparam int FontW      = 8;
  localparam int PixPerByte = 8;
  localparam int OrgW       = 11;
  localparam int RowBytesW  = 4;
  localparam int GlyphRowsW = 7;
  localparam int ColorW     = 32;
  localparam int AddrW      = 19;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int QDepth     = 4;

  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_BYTES  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_ROWS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INK_COLOR  = 3'd4;

  typedef struct packed {
    logic signed [OrgW-1:0] origin_x;
    logic signed [OrgW-1:0] origin_y;
    logic [RowBytesW-1:0]   row_bytes;
    logic [GlyphRowsW-1:0]  glyph_rows;
  } gbb_geom_t;

  // mask bit 0 is the leftmost pixel; base is the address of that pixel
  typedef struct packed {
    logic [PixPerByte-1:0] mask;
    logic [AddrW-1:0]      base;
  } gbb_job_t;

endpackage

### sv/gbb_front.sv
// gbb_front: byte intake, glyph column/row counters and clipping.
// Emits one job (visible pixel mask, base address) per in-glyph byte with visible ink.
// Depends on gbb_pkg.
module gbb_front import gbb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 480,
  parameter int MAX_ROW_BYTES = 8,
  parameter int MAX_ROWS      = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  gbb_geom_t        geom,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  logic [FontW-1:0] font_byte,
  input  logic             glyph_start,
  input  logic             q_full,
  output logic             q_push,
  output gbb_job_t         q_job
);

  localparam int ColW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int RowW   = $clog2(MAX_ROWS);
  localparam int RbW    = ($clog2(MAX_ROW_BYTES + 1) > RowBytesW) ?
                          $clog2(MAX_ROW_BYTES + 1) : RowBytesW;
  localparam int RowsW  = ($clog2(MAX_ROWS + 1) > GlyphRowsW) ?
                          $clog2(MAX_ROWS + 1) : GlyphRowsW;
  localparam int XW     = (($clog2(SCREEN_WIDTH + 1) > OrgW) ?
                          $clog2(SCREEN_WIDTH + 1) : OrgW) + 1;
  localparam int YW     = (($clog2(SCREEN_HEIGHT + 1) > OrgW) ?
                          $clog2(SCREEN_HEIGHT + 1) : OrgW) + 1;

  logic [ColW-1:0] byte_column, byte_column_next;
  logic [RowW-1:0] pixel_row, pixel_row_next;
  logic            glyph_done, glyph_done_next;

  logic [RbW-1:0]         rb;
  logic [RowsW-1:0]       rows;
  logic [ColW-1:0]        col_eff;
  logic [RowW-1:0]        row_eff;
  logic                   active;
  logic                   accept;
  logic signed [XW-1:0]   x0;
  logic signed [YW-1:0]   y0;
  logic                   y_ok;
  logic signed [XW-1:0]   xk [PixPerByte];
  logic [PixPerByte-1:0]  mask;
  logic [AddrW-1:0]       y_lin;

  always_comb begin
    if (geom.row_bytes == '0) begin
      rb = RbW'(1);
    end else if (RbW'(geom.row_bytes) > RbW'(MAX_ROW_BYTES)) begin
      rb = RbW'(MAX_ROW_BYTES);
    end else begin
      rb = RbW'(geom.row_bytes);
    end
    if (geom.glyph_rows == '0) begin
      rows = RowsW'(1);
    end else if (RowsW'(geom.glyph_rows) > RowsW'(MAX_ROWS)) begin
      rows = RowsW'(MAX_ROWS);
    end else begin
      rows = RowsW'(geom.glyph_rows);
    end
  end

  assign col_eff = glyph_start ? '0 : byte_column;
  assign row_eff = glyph_start ? '0 : pixel_row;
  assign active  = glyph_start || !glyph_done;

  assign x0   = XW'(geom.origin_x) + $signed(XW'({col_eff, 3'b000}));
  assign y0   = YW'(geom.origin_y) + $signed(YW'(row_eff));
  assign y_ok = (y0 >= 0) && (y0 < $signed(YW'(SCREEN_HEIGHT)));

  always_comb begin
    for (int k = 0; k < PixPerByte; k++) begin
      xk[k]   = x0 + $signed(XW'(k));
      mask[k] = font_byte[PixPerByte-1-k] && y_ok && (xk[k] >= 0) &&
                (xk[k] < $signed(XW'(SCREEN_WIDTH)));
    end
  end

  assign y_lin      = AddrW'(y0);
  assign q_job.mask = mask;
  assign q_job.base = y_lin * AddrW'(SCREEN_WIDTH) + AddrW'(x0);

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign q_push     = accept && active && (mask != '0);

  always_comb begin
    byte_column_next = byte_column;
    pixel_row_next   = pixel_row;
    glyph_done_next  = glyph_done;
    if (accept && active) begin
      glyph_done_next = 1'b0;
      if (RbW'(col_eff) + RbW'(1) >= rb) begin
        byte_column_next = '0;
        if (RowsW'(row_eff) + RowsW'(1) >= rows) begin
          pixel_row_next  = '0;
          glyph_done_next = 1'b1;
        end else begin
          pixel_row_next = RowW'(RowsW'(row_eff) + RowsW'(1));
        end
      end else begin
        byte_column_next = ColW'(RbW'(col_eff) + RbW'(1));
        pixel_row_next   = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      pixel_row   <= '0;
      glyph_done  <= 1'b1;
    end else begin
      byte_column <= byte_column_next;
      pixel_row   <= pixel_row_next;
      glyph_done  <= glyph_done_next;
    end
  end

endmodule

### sv/gbb_queue.sv
// gbb_queue: small job FIFO between the front and back ends.
// Depends on gbb_pkg.
module gbb_queue import gbb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  gbb_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     job_valid,
  output gbb_job_t job
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  gbb_job_t        entries [QDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_pop;

  assign full      = (count == CntW'(QDepth));
  assign job_valid = (count != '0);
  assign job       = entries[rd_ptr];
  assign do_pop    = pop && job_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

### sv/gbb_back.sv
// gbb_back: walks each job's pixel mask left to right, one pixel write per
// cycle while the output is not stalled, into an output register. Depends on gbb_pkg.
module gbb_back import gbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  gbb_job_t          job,
  output logic              pop,
  input  logic [ColorW-1:0] ink_color,
  output logic              m_valid,
  input  logic              m_ready,
  output logic [AddrW-1:0]  m_addr,
  output logic [ColorW-1:0] m_value,
  output logic              m_last
);

  localparam int SelW = $clog2(PixPerByte);

  logic [PixPerByte-1:0] cur_mask;
  logic [AddrW-1:0]      cur_base;
  logic [PixPerByte-1:0] remaining;
  logic [SelW-1:0]       sel;
  logic                  emit;
  logic                  load;

  always_comb begin
    sel = '0;
    for (int k = PixPerByte - 1; k >= 0; k--) begin
      if (cur_mask[k]) begin
        sel = SelW'(k);
      end
    end
  end

  assign remaining = cur_mask & ~(PixPerByte'(1) << sel);
  assign emit      = (cur_mask != '0) && (!m_valid || m_ready);
  assign load      = (cur_mask == '0) || (emit && (remaining == '0));
  assign pop       = load && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
      m_valid  <= 1'b0;
    end else begin
      if (pop) begin
        cur_mask <= job.mask;
      end else if (emit) begin
        cur_mask <= remaining;
      end
      if (emit) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_base <= job.base;
    end
    if (emit) begin
      m_addr  <= cur_base + AddrW'(sel);
      m_value <= ink_color;
      m_last  <= (remaining == '0);
    end
  end

`ifndef SYNTH
  a_stall_holds_mask: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_ready && (cur_mask != '0)) |=> $stable(cur_mask))
    else $error("pixel mask advanced while output stalled");

  a_job_has_ink: assert property (@(posedge clk) disable iff (rst)
    pop |-> (job.mask != '0))
    else $error("empty job reached back end");

  a_no_output_without_work: assert property (@(posedge clk) disable iff (rst)
    (!m_valid && (cur_mask == '0)) |=> !m_valid)
    else $error("pixel write without pending job");
`endif

endmodule

### sv/glyph_bitmap_blitter.sv
// glyph_bitmap_blitter: top level. Configuration registers, front end,
// job queue and pixel back end. Depends on gbb_pkg, gbb_front, gbb_queue, gbb_back.
//
// Takes one glyph bitmap byte per transfer (MSB is the leftmost pixel, tuser
// high on a glyph's first byte) and produces one framebuffer write per set,
// on-panel bit, left to right, with tlast on the final write of each byte.
// A byte is taken every cycle while the four-entry job queue has room; the
// write side issues one pixel per cycle while the output is not stalled, so a
// byte costs as many output writes as it has visible set bits, and clear or clipped
// bytes cost none. Sustained rate is therefore set by the single pixel-write port.
// Write registers only while no writes are pending.
module glyph_bitmap_blitter import gbb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 480,
  parameter int MAX_ROW_BYTES = 8,
  parameter int MAX_ROWS      = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // font_byte
  input  logic                s_tuser,   // glyph_start
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [55:0]         m_tdata,   // pixel_address[18:0], pixel_value[50:19]
  output logic                m_tlast    // last_of_byte
);

  localparam int OutBits = AddrW + ColorW;
  localparam int OutPad  = 56 - OutBits;

  gbb_geom_t         geom;
  logic [ColorW-1:0] ink_color;

  logic              q_full;
  logic              q_push;
  gbb_job_t          q_job;
  logic              job_pop;
  logic              job_valid;
  gbb_job_t          job;
  logic [AddrW-1:0]  m_addr;
  logic [ColorW-1:0] m_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.origin_x   <= '0;
      geom.origin_y   <= '0;
      geom.row_bytes  <= RowBytesW'(1);
      geom.glyph_rows <= GlyphRowsW'(16);
      ink_color       <= ColorW'(32'h00FF_FFFF);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:   geom.origin_x   <= cfg_data[OrgW-1:0];
        CFG_ORIGIN_Y:   geom.origin_y   <= cfg_data[OrgW-1:0];
        CFG_ROW_BYTES:  geom.row_bytes  <= cfg_data[RowBytesW-1:0];
        CFG_GLYPH_ROWS: geom.glyph_rows <= cfg_data[GlyphRowsW-1:0];
        CFG_INK_COLOR:  ink_color       <= cfg_data[ColorW-1:0];
        default: ;
      endcase
    end
  end

  gbb_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .MAX_ROWS     (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .byte_valid (s_tvalid),
    .byte_ready (s_tready),
    .font_byte  (s_tdata[FontW-1:0]),
    .glyph_start(s_tuser),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  gbb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (job_pop),
    .job_valid(job_valid),
    .job      (job)
  );

  gbb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job),
    .pop      (job_pop),
    .ink_color(ink_color),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_addr   (m_addr),
    .m_value  (m_value),
    .m_last   (m_tlast)
  );

  assign m_tdata = {OutPad'(0), m_value, m_addr};

endmodule

### tb/testbench.sv
// testbench: self-checking bench for glyph_bitmap_blitter. Drives font bytes and
// register writes, predicts every pixel write in a scoreboard class and checks them.
// Depends on gbb_pkg and the glyph_bitmap_blitter RTL.
module testbench;
  import gbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ScreenW      = 800;
  localparam int ScreenH      = 480;
  localparam int MaxRowBytes  = 8;
  localparam int MaxRows      = 64;
  localparam int RandItems    = 310;
  localparam int SettleCycles = 32;
  localparam int CycleLimit   = 600000;
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd7;

  typedef struct {
    logic [AddrW-1:0]  addr;
    logic [ColorW-1:0] color;
    logic              last;
  } pix_write_t;

  class blit_scoreboard;
    logic [OrgW-1:0]       org_x;
    logic [OrgW-1:0]       org_y;
    logic [RowBytesW-1:0]  row_bytes;
    logic [GlyphRowsW-1:0] glyph_rows;
    logic [ColorW-1:0]     ink;
    int                    col;
    int                    row;
    bit                    no_glyph;
    pix_write_t            writes_due[$];
    int                    errors;
    int                    writes_seen;
    int                    bytes_drawn;
    int                    cfg_writes;

    function new();
      org_x = '0;
      org_y = '0;
      row_bytes = 4'd1;
      glyph_rows = 7'd16;
      ink = 32'h00FF_FFFF;
      col = 0;
      row = 0;
      no_glyph = 1'b1;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      cfg_writes++;
      case (idx)
        CFG_ORIGIN_X:   org_x = data[OrgW-1:0];
        CFG_ORIGIN_Y:   org_y = data[OrgW-1:0];
        CFG_ROW_BYTES:  row_bytes = data[RowBytesW-1:0];
        CFG_GLYPH_ROWS: glyph_rows = data[GlyphRowsW-1:0];
        CFG_INK_COLOR:  ink = data[ColorW-1:0];
        default: ;
      endcase
    endfunction

    function int width_bytes();
      if (row_bytes == 0) return 1;
      return (row_bytes > MaxRowBytes) ? MaxRowBytes : int'(row_bytes);
    endfunction

    function int height_rows();
      if (glyph_rows == 0) return 1;
      return (glyph_rows > MaxRows) ? MaxRows : int'(glyph_rows);
    endfunction

    // expand one accepted byte into the writes it must cause
    function void note_byte(logic [7:0] fbyte, logic start);
      int ox;
      int oy;
      int x;
      int y;
      pix_write_t hits[$];
      pix_write_t w;
      if (start) begin
        col = 0;
        row = 0;
        no_glyph = 1'b0;
      end
      if (no_glyph) return;
      bytes_drawn++;
      ox = $signed(org_x);
      oy = $signed(org_y);
      y = oy + row;
      for (int b = 7; b >= 0; b--) begin
        x = ox + col * 8 + (7 - b);
        if (fbyte[b] && x >= 0 && x < ScreenW && y >= 0 && y < ScreenH) begin
          w.addr = AddrW'(x + y * ScreenW);
          w.color = ink;
          w.last = 1'b0;
          hits.push_back(w);
        end
      end
      if (hits.size() > 0) hits[hits.size() - 1].last = 1'b1;
      foreach (hits[i]) writes_due.push_back(hits[i]);
      if (col + 1 >= width_bytes()) begin
        col = 0;
        if (row + 1 >= height_rows()) begin
          row = 0;
          no_glyph = 1'b1;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
    endfunction

    function void check_write(logic [55:0] tdata, logic tlast);
      pix_write_t w;
      writes_seen++;
      if (writes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel write addr %0d value %h last %b", $time,
                 tdata[AddrW-1:0], tdata[AddrW +: ColorW], tlast);
        return;
      end
      w = writes_due.pop_front();
      if (tdata[AddrW-1:0] !== w.addr) begin
        errors++;
        $display("%0t: pixel_address expected %0d actual %0d", $time, w.addr,
                 tdata[AddrW-1:0]);
      end
      if (tdata[AddrW +: ColorW] !== w.color) begin
        errors++;
        $display("%0t: pixel_value expected %h actual %h", $time, w.color,
                 tdata[AddrW +: ColorW]);
      end
      if (tlast !== w.last) begin
        errors++;
        $display("%0t: last_of_byte expected %b actual %b", $time, w.last, tlast);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;   // font_byte
  logic                s_tuser = 1'b0; // glyph_start
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [55:0]         m_tdata;        // pixel_address[18:0], pixel_value[50:19]
  logic                m_tlast;        // last_of_byte

  blit_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int             rcv_hold = 0;
  int             cycle_count = 0;

  glyph_bitmap_blitter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rcv_hold > 0) begin
      m_tready <= 1'b0;
      rcv_hold <= rcv_hold - 1;
    end else begin
      m_tready <= 1'b1;
      rcv_hold <= pick_gap();
    end
  end

  // predict on every input transfer, then check every output transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_write(m_tdata, m_tlast);
    end
  end

  task automatic send_byte(input logic [7:0] fbyte, input logic start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= fbyte;
    s_tuser <= start;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.writes_due.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic random_setup();
    int ox;
    int oy;
    int rb;
    int rows;
    case ($urandom_range(0, 9))
      0: ox = -1024;
      1: ox = 1023;
      default: ox = int'($urandom_range(0, 836)) - 20;
    endcase
    case ($urandom_range(0, 9))
      0: oy = -1024;
      1: oy = 1023;
      default: oy = int'($urandom_range(0, 500)) - 10;
    endcase
    case ($urandom_range(0, 9))
      0: rb = 0;
      1: rb = $urandom_range(8, 15);
      default: rb = $urandom_range(1, 3);
    endcase
    case ($urandom_range(0, 11))
      0: rows = 0;
      1: rows = (rb > 3) ? $urandom_range(1, 4) : $urandom_range(64, 127);
      default: rows = $urandom_range(1, 8);
    endcase
    if (rows > 8) rb = 1;
    else if (rb > 3 && rows > 4) rows = 4;
    if ($urandom_range(0, 3) != 0) write_reg(CFG_ORIGIN_X, 32'(ox));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_ORIGIN_Y, 32'(oy));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_ROW_BYTES, 32'(rb));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_GLYPH_ROWS, 32'(rows));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_INK_COLOR, $urandom());
    if ($urandom_range(0, 15) == 0) write_reg(CfgUnusedIdx, $urandom());
  endtask

  function automatic logic [7:0] random_font_byte();
    case ($urandom_range(0, 9))
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic random_phase();
    int n;
    int kind;
    n = sb.width_bytes() * sb.height_rows();
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      for (int i = 0; i < n; i++) begin
        send_byte(random_font_byte(), i == 0);
        if ($urandom_range(0, 59) == 0) drain();
      end
      repeat ($urandom_range(0, 2)) send_byte(random_font_byte(), 1'b0);
    end else if (kind < 9) begin
      repeat ($urandom_range(1, n)) send_byte(random_font_byte(), $urandom_range(0, 7) == 0);
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(random_font_byte(), 1'b0);
    end
  endtask

  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry: one byte wide, 16 rows, at the panel origin
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hA5, 1'b1);
    settle();

    // zero width and height act as one; left edge clips
    write_reg(CFG_ORIGIN_X, -32'sd4);
    write_reg(CFG_ROW_BYTES, 32'd0);
    write_reg(CFG_GLYPH_ROWS, 32'd0);
    write_reg(CFG_INK_COLOR, 32'd0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    settle();

    // oversized geometry clamps; bottom-right corner clips
    write_reg(CFG_ORIGIN_X, 32'd796);
    write_reg(CFG_ORIGIN_Y, 32'd479);
    write_reg(CFG_ROW_BYTES, 32'd15);
    write_reg(CFG_GLYPH_ROWS, 32'd127);
    write_reg(CFG_INK_COLOR, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h0F, 1'b1);
    settle();

    // fully off-panel origin, plus a write to an unused index
    write_reg(CFG_ORIGIN_X, 32'd1023);
    write_reg(CFG_ORIGIN_Y, -32'sd1024);
    write_reg(CfgUnusedIdx, 32'h5A5A_A5A5);
    send_byte(8'hFF, 1'b1);
    settle();

    // geometry changed in the middle of a glyph
    write_reg(CFG_ORIGIN_X, 32'd0);
    write_reg(CFG_ORIGIN_Y, -32'sd1);
    write_reg(CFG_ROW_BYTES, 32'd3);
    write_reg(CFG_GLYPH_ROWS, 32'd3);
    write_reg(CFG_INK_COLOR, 32'h1234_5678);
    send_byte(8'hF0, 1'b1);
    send_byte(8'h3C, 1'b0);
    settle();
    write_reg(CFG_ORIGIN_Y, 32'd478);
    write_reg(CFG_ROW_BYTES, 32'd1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();

    target = sb.bytes_drawn + RandItems;
    while (sb.bytes_drawn < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      random_setup();
      random_phase();
      settle();
    end
    no_idle = 1'b0;

    $display("Run covered %0d drawn glyph bytes and %0d pixel writes across %0d register writes.",
             sb.bytes_drawn, sb.writes_seen, sb.cfg_writes);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches found", sb.errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles, %0d writes still expected", cycle_count,
             sb.writes_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
